// ===== rtl/iirl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the indexed insert/remove list.
// No dependencies.
package iirl_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
    localparam logic [CNT_W-1:0] DEPTH_CNT = 7'd64;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic             ins_en;
        logic             rem_en;
        logic [CNT_W-1:0] pos;
    } cell_ctrl_t;

endpackage

// ===== rtl/iirl_cell.sv =====
`timescale 1ns / 1ps
// One list slot: holds a word, loads it, or takes its left/right neighbor's.
// Depends on iirl_pkg.
module iirl_cell (
    input  logic                                   clk,
    input  iirl_pkg::cell_ctrl_t                   ctrl,
    input  logic [iirl_pkg::IDX_W-1:0]             idx,
    input  logic signed [iirl_pkg::DATA_W-1:0]     ins_data,
    input  logic signed [iirl_pkg::DATA_W-1:0]     left_data,
    input  logic signed [iirl_pkg::DATA_W-1:0]     right_data,
    output logic signed [iirl_pkg::DATA_W-1:0]     data
);

    logic signed [iirl_pkg::DATA_W-1:0] data_reg;
    logic signed [iirl_pkg::DATA_W-1:0] data_next;
    logic [iirl_pkg::CNT_W-1:0]         idx_ext;

    assign idx_ext = {1'b0, idx};

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (idx_ext == ctrl.pos)
                data_next = ins_data;
            else if (idx_ext > ctrl.pos)
                data_next = left_data;
        end
        else if (ctrl.rem_en)
        begin
            if (idx_ext >= ctrl.pos)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/indexed_insert_remove_list.sv =====
`timescale 1ns / 1ps
// Fixed-capacity ordered list of signed words held in a row of shift cells.
// The result is registered as the item is accepted.
// Throughput: one item per cycle while out_ready holds; insert/remove shift all cells in parallel.
// Reset: count cleared, capacity 64, out_valid cleared; entry words and result fields not reset.
// Depends on iirl_pkg and iirl_cell.
module indexed_insert_remove_list (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             mode,
    input  logic [iirl_pkg::CNT_W-1:0]             position,
    input  logic signed [iirl_pkg::DATA_W-1:0]     value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             status,
    output logic signed [iirl_pkg::DATA_W-1:0]     read_value,
    output logic [iirl_pkg::CNT_W-1:0]             count,
    output logic                                   is_full,
    output logic                                   is_empty,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [iirl_pkg::CNT_W-1:0]             cfg_data
);

    logic [iirl_pkg::CNT_W-1:0] cap_reg;
    logic [iirl_pkg::CNT_W-1:0] cnt_reg;
    logic [iirl_pkg::CNT_W-1:0] cnt_next;
    logic [iirl_pkg::CNT_W-1:0] eff_cap;
    logic                       out_valid_reg;
    logic                       accept;

    logic [1:0]                         status_reg, status_next;
    logic signed [iirl_pkg::DATA_W-1:0] rd_reg, rd_next;
    logic [iirl_pkg::CNT_W-1:0]         count_reg;
    logic                               full_reg, full_next;
    logic                               empty_reg, empty_next;

    iirl_pkg::cell_ctrl_t ctrl;
    logic signed [iirl_pkg::DATA_W-1:0] cell_data [iirl_pkg::DEPTH];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign eff_cap   = (cap_reg > iirl_pkg::DEPTH_CNT) ? iirl_pkg::DEPTH_CNT : cap_reg;

    always_comb
    begin
        status_next = iirl_pkg::ST_OK;
        rd_next     = '1;
        cnt_next    = cnt_reg;
        ctrl.ins_en = 1'b0;
        ctrl.rem_en = 1'b0;
        ctrl.pos    = position;
        case (mode)
            iirl_pkg::MODE_INSERT:
            begin
                if (position > cnt_reg)
                    status_next = iirl_pkg::ST_INVALID;
                else if (cnt_reg >= eff_cap)
                    status_next = iirl_pkg::ST_FULL;
                else
                begin
                    ctrl.ins_en = accept;
                    cnt_next    = cnt_reg + 7'd1;
                end
            end
            iirl_pkg::MODE_REMOVE:
            begin
                if (position >= cnt_reg)
                    status_next = iirl_pkg::ST_INVALID;
                else
                begin
                    ctrl.rem_en = accept;
                    cnt_next    = cnt_reg - 7'd1;
                end
            end
            iirl_pkg::MODE_READ:
            begin
                if (position >= cnt_reg)
                    status_next = iirl_pkg::ST_INVALID;
                else
                    rd_next = cell_data[position[iirl_pkg::IDX_W-1:0]];
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
        full_next  = (cnt_next >= eff_cap);
        empty_next = (cnt_next == '0);
    end

    genvar g;
    generate
        for (g = 0; g < iirl_pkg::DEPTH; g++)
        begin : g_cell
            logic signed [iirl_pkg::DATA_W-1:0] left_d;
            logic signed [iirl_pkg::DATA_W-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[g-1];
            end
            if (g == iirl_pkg::DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_data[g+1];
            end
            iirl_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .idx        (iirl_pkg::IDX_W'(g)),
                .ins_data   (value),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= iirl_pkg::CAP_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (accept)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
            count_reg  <= cnt_next;
            full_reg   <= full_next;
            empty_reg  <= empty_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = rd_reg;
    assign count      = count_reg;
    assign is_full    = full_reg;
    assign is_empty   = empty_reg;

endmodule
